@@ rtl/core/cfkf_pkg.sv @@
// Shared types and constants for the credential field keyword filter.
`timescale 1ns / 1ps

package cfkf_pkg;

   localparam int LIMIT_W    = 6;
   localparam int WINDOW_LEN = 7;
   localparam int KW_COUNT   = 12;
   localparam int KW_MAX     = 8;
   localparam int CSR_IDX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN_ACCOUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN_ACCOUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN_NICK    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN_NICK    = 2'd3;

   // Verdict codes.
   localparam logic [2:0] REASON_OK        = 3'd0;
   localparam logic [2:0] REASON_BAD_CHAR  = 3'd1;
   localparam logic [2:0] REASON_KEYWORD   = 3'd2;
   localparam logic [2:0] REASON_TOO_SHORT = 3'd3;
   localparam logic [2:0] REASON_TOO_LONG  = 3'd4;

   localparam logic [LIMIT_W-1:0] RST_MIN_LEN_ACCOUNT = 6'd6;
   localparam logic [LIMIT_W-1:0] RST_MAX_LEN_ACCOUNT = 6'd10;
   localparam logic [LIMIT_W-1:0] RST_MIN_LEN_NICK    = 6'd2;
   localparam logic [LIMIT_W-1:0] RST_MAX_LEN_NICK    = 6'd10;

   // Keywords are right aligned: byte 0 holds the final letter.
   localparam logic [KW_MAX*8-1:0] KEYWORDS [KW_COUNT] = '{
      64'("OR"), 64'("SELECT"), 64'("INSERT"), 64'("DELETE"),
      64'("UPDATE"), 64'("CREATE"), 64'("DROP"), 64'("EXEC"),
      64'("UNION"), 64'("FETCH"), 64'("DECLARE"), 64'("TRUNCATE")
   };
   localparam logic [3:0] KEYWORD_LEN [KW_COUNT] = '{
      4'd2, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5, 4'd7, 4'd8
   };

   typedef struct packed {
      logic [7:0] char_byte;
      logic       string_kind;
      logic       last_char;
   } cfkf_req_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] reason;
   } cfkf_rsp_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] min_len_account;
      logic [LIMIT_W-1:0] max_len_account;
      logic [LIMIT_W-1:0] min_len_nick;
      logic [LIMIT_W-1:0] max_len_nick;
   } cfkf_limits_type;

   typedef struct packed {
      logic bad_char;
      logic keyword;
   } cfkf_flags_type;

   // Byte 0 of the window is the current byte, byte m the one m items back.
   function automatic logic keyword_hit(input logic [KW_MAX-1:0][7:0] win);
      logic hit;
      logic match;
      hit = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         match = 1'b1;
         for (int m = 0; m < KW_MAX; m++) begin
            if (m < int'(KEYWORD_LEN[k]) && win[m] != KEYWORDS[k][m*8 +: 8]) begin
               match = 1'b0;
            end
         end
         hit = hit | match;
      end
      return hit;
   endfunction

endpackage

@@ rtl/core/cfkf_csr.sv @@
// Length limit registers written through the configuration port.
`timescale 1ns / 1ps

module cfkf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfkf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfkf_pkg::LIMIT_W-1:0]    csr_wdata,
   output cfkf_pkg::cfkf_limits_type       limits
);
   import cfkf_pkg::*;

   cfkf_limits_type limits_ff;
   cfkf_limits_type limits_in;

   assign csr_ready = 1'b1;
   assign limits    = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_LEN_ACCOUNT: limits_in.min_len_account = csr_wdata;
            CSR_MAX_LEN_ACCOUNT: limits_in.max_len_account = csr_wdata;
            CSR_MIN_LEN_NICK:    limits_in.min_len_nick    = csr_wdata;
            CSR_MAX_LEN_NICK:    limits_in.max_len_nick    = csr_wdata;
            default:             limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.min_len_account <= RST_MIN_LEN_ACCOUNT;
         limits_ff.max_len_account <= RST_MAX_LEN_ACCOUNT;
         limits_ff.min_len_nick    <= RST_MIN_LEN_NICK;
         limits_ff.max_len_nick    <= RST_MAX_LEN_NICK;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

@@ rtl/core/cfkf_scan.sv @@
// Per-string state: byte window, keyword match, character check and length count.
`timescale 1ns / 1ps

module cfkf_scan #(
   parameter int MAX_COUNT = 63,
   parameter int CNT_W     = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  cfkf_pkg::cfkf_req_type     item,
   output cfkf_pkg::cfkf_flags_type   flags,
   output logic [CNT_W-1:0]           length
);
   import cfkf_pkg::*;

   logic [WINDOW_LEN-1:0][7:0] recent_ff;
   logic [WINDOW_LEN-1:0][7:0] recent_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   cfkf_flags_type             seen_ff;
   cfkf_flags_type             seen_in;
   logic                       alnum;
   logic [7:0]                 c;

   assign c     = item.char_byte;
   assign alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
                  (c >= 8'h61 && c <= 8'h7a);

   // Flags and length including the current byte.
   assign flags.bad_char = seen_ff.bad_char | ~alnum;
   assign flags.keyword  = seen_ff.keyword | keyword_hit({recent_ff, c});
   assign length = (count_ff < CNT_W'(MAX_COUNT)) ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      recent_in = recent_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      if (step) begin
         if (item.last_char) begin
            recent_in = '0;
            count_in  = '0;
            seen_in   = '0;
         end else begin
            recent_in = {recent_ff[WINDOW_LEN-2:0], c};
            count_in  = length;
            seen_in   = flags;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         count_ff  <= '0;
         seen_ff   <= '0;
      end else begin
         recent_ff <= recent_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

@@ rtl/core/credential_field_keyword_filter.sv @@
// Top level of the credential field keyword filter.
//
//   channel | direction | payload          | handshake
//   req     | in        | cfkf_req_type    | req_valid / req_ready
//   rsp     | out       | cfkf_rsp_type    | rsp_valid / rsp_ready
//   csr     | in        | index, 6-bit data| csr_valid / csr_ready (always ready)
//
// One item per cycle while no verdict waits with rsp_ready low: a byte goes
// into the input register, and when it advances the string state updates
// and, on a last byte, the verdict is loaded into the result register.
// The input register holds only while a verdict waits with rsp_ready low.
// Reset restores the default limits and clears the string state.
`timescale 1ns / 1ps

module credential_field_keyword_filter #(
   parameter int MAX_COUNT = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cfkf_pkg::cfkf_req_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cfkf_pkg::cfkf_rsp_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfkf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cfkf_pkg::LIMIT_W-1:0]    csr_wdata
);
   import cfkf_pkg::*;

   localparam int CNT_W = $clog2(MAX_COUNT + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   cfkf_req_type    s1_item_ff;
   cfkf_req_type    s1_item_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   cfkf_rsp_type    rsp_data_ff;
   cfkf_rsp_type    rsp_data_in;
   logic            advance;
   cfkf_limits_type limits;
   cfkf_flags_type  flags;
   logic [CNT_W-1:0] length;
   logic [CMP_W-1:0] len_x;
   logic [CMP_W-1:0] lo_x;
   logic [CMP_W-1:0] hi_x;
   logic [2:0]       reason;

   cfkf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   cfkf_scan #(
      .MAX_COUNT (MAX_COUNT),
      .CNT_W     (CNT_W)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .flags  (flags),
      .length (length)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      len_x = CMP_W'(length);
      lo_x  = s1_item_ff.string_kind ? CMP_W'(limits.min_len_nick)
                                     : CMP_W'(limits.min_len_account);
      hi_x  = s1_item_ff.string_kind ? CMP_W'(limits.max_len_nick)
                                     : CMP_W'(limits.max_len_account);
      priority if (flags.bad_char) begin
         reason = REASON_BAD_CHAR;
      end else if (flags.keyword) begin
         reason = REASON_KEYWORD;
      end else if (len_x < lo_x) begin
         reason = REASON_TOO_SHORT;
      end else if (len_x > hi_x) begin
         reason = REASON_TOO_LONG;
      end else begin
         reason = REASON_OK;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && s1_item_ff.last_char) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.reason   = reason;
         rsp_data_in.accepted = (reason == REASON_OK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
